// File: design/two_led_blink_timer_top_assert.svh
// Assertion macros shared by the LED blink timer RTL.
`ifndef TWO_LED_BLINK_TIMER_TOP_ASSERT_SVH
`define TWO_LED_BLINK_TIMER_TOP_ASSERT_SVH

`ifndef NO_ASSERTIONS
// Clocked property, disabled while reset is high.
`define TLBT_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("tlbt assertion failed");
// Clocked property that also holds during reset.
`define TLBT_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("tlbt assertion failed");
`else
`define TLBT_ASSERT(label, clk, rst, prop)
`define TLBT_ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

// File: design/tlbt_pkg.sv
// Types and constants of the two channel LED blink timer.
`timescale 1ns / 1ps

package tlbt_pkg;

   localparam int MAX_CHANNELS     = 2;
   localparam int CHANNEL_COUNT    = 2;
   localparam int TIMER_WIDTH      = 18;
   localparam int SPAN_WIDTH       = 16;
   localparam int STEP_WIDTH       = 8;
   localparam int CSR_INDEX_WIDTH  = 3;
   localparam int CSR_DATA_WIDTH   = 16;
   localparam logic [SPAN_WIDTH-1:0] SPAN_RESET = 16'd10;

   // Channel modes; code 3 has no meaning and holds like manual.
   typedef enum logic [1:0] {
      MODE_FLASH  = 2'd0,
      MODE_BLINK  = 2'd1,
      MODE_MANUAL = 2'd2
   } tlbt_mode_type;

   // Item actions.
   localparam logic ACT_TICK    = 1'b0;
   localparam logic ACT_CONTROL = 1'b1;

   // Register indexes.
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_GREEN_MODE     = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_GREEN_ON_SPAN  = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_GREEN_OFF_SPAN = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_GREEN_INVERT   = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_RED_MODE       = 3'd4;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_RED_ON_SPAN    = 3'd5;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_RED_OFF_SPAN   = 3'd6;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_RED_INVERT     = 3'd7;

   // Per channel configuration handed to a channel.
   typedef struct packed {
      logic [1:0]            mode;
      logic [SPAN_WIDTH-1:0] on_span;
      logic [SPAN_WIDTH-1:0] off_span;
      logic                  invert;
   } tlbt_chan_cfg_type;

   // Per channel status after the item.
   typedef struct packed {
      logic pin;
      logic armed;
   } tlbt_chan_out_type;

   // One result item.
   typedef struct packed {
      logic green_pin;
      logic red_pin;
      logic green_flash_pending;
      logic red_flash_pending;
   } tlbt_rsp_type;

endpackage

// File: design/tlbt_channel.sv
// One LED channel: phase timer, level, flash arm, force-off and pin.
`timescale 1ns / 1ps
`include "two_led_blink_timer_top_assert.svh"

module tlbt_channel (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 tick,
   input  logic                                 ctl,
   input  logic [tlbt_pkg::STEP_WIDTH-1:0]      step,
   input  logic                                 flash_request,
   input  logic                                 off_request,
   input  logic                                 manual_level,
   input  tlbt_pkg::tlbt_chan_cfg_type          cfg,
   output tlbt_pkg::tlbt_chan_out_type          status
);

   localparam int TW = tlbt_pkg::TIMER_WIDTH;
   localparam int SW = tlbt_pkg::SPAN_WIDTH;

   logic [TW-1:0] timer_ff, timer_in;
   logic          lit_ff, lit_in;
   logic          armed_ff, armed_in;
   logic          force_ff, force_in;
   logic          pin_ff, pin_in;

   logic [SW:0]   period;
   logic [TW-1:0] period_ext;
   logic [TW-1:0] on_ext;
   logic [TW-1:0] sum;

   // Period and advanced timer
   always_comb begin
      period     = {1'b0, cfg.on_span} + {1'b0, cfg.off_span};
      period_ext = {{(TW-SW-1){1'b0}}, period};
      on_ext     = {{(TW-SW){1'b0}}, cfg.on_span};
      sum        = timer_ff + {{(TW-tlbt_pkg::STEP_WIDTH){1'b0}}, step};
   end

   // Next state for tick and control items
   always_comb begin
      timer_in = timer_ff;
      lit_in   = lit_ff;
      armed_in = armed_ff;
      force_in = force_ff;
      pin_in   = pin_ff;
      if (tick) begin
         if (force_ff) begin
            lit_in   = 1'b0;
            timer_in = '0;
         end else begin
            unique case (cfg.mode)
               tlbt_pkg::MODE_FLASH: begin
                  if (armed_ff) begin
                     lit_in = (sum < on_ext);
                     if (sum > period_ext) begin
                        timer_in = '0;
                        armed_in = 1'b0;
                     end else begin
                        timer_in = sum;
                     end
                  end else begin
                     lit_in   = 1'b0;
                     timer_in = '0;
                  end
               end
               tlbt_pkg::MODE_BLINK: begin
                  lit_in   = (sum < on_ext);
                  timer_in = (sum >= period_ext) ? '0 : sum;
               end
               default: begin
                  // manual level, and the unused code: hold
               end
            endcase
         end
         pin_in = lit_in ^ cfg.invert;
      end else if (ctl) begin
         armed_in = armed_ff | flash_request;
         force_in = off_request;
         lit_in   = manual_level;
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         timer_ff <= '0;
         lit_ff   <= 1'b0;
         armed_ff <= 1'b0;
         force_ff <= 1'b0;
         pin_ff   <= 1'b0;
      end else begin
         timer_ff <= timer_in;
         lit_ff   <= lit_in;
         armed_ff <= armed_in;
         force_ff <= force_in;
         pin_ff   <= pin_in;
      end
   end

   assign status.pin   = pin_in;
   assign status.armed = armed_in;

   `TLBT_ASSERT(a_force_clears, clock, reset, tick && force_ff |=> timer_ff == '0 && !lit_ff)
   `TLBT_ASSERT(a_manual_holds, clock, reset, tick && !force_ff && cfg.mode == tlbt_pkg::MODE_MANUAL |=> $stable(timer_ff))
   `TLBT_ASSERT(a_ctl_keeps_pin, clock, reset, ctl |=> $stable(pin_ff))

endmodule

// File: design/tlbt_skid.sv
// Two entry result queue between the channel logic and the result port.
`timescale 1ns / 1ps
`include "two_led_blink_timer_top_assert.svh"

module tlbt_skid (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  tlbt_pkg::tlbt_rsp_type push_data,
   output logic                   has_room,
   output logic                   out_valid,
   input  logic                   out_ready,
   output tlbt_pkg::tlbt_rsp_type out_data
);

   tlbt_pkg::tlbt_rsp_type slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       pop;

   assign has_room  = (count_ff != 2'd2);
   assign out_valid = (count_ff != 2'd0);
   assign out_data  = slot_ff[rd_ptr_ff];
   assign pop       = out_valid && out_ready;

   // Pointer and fill count
   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Payload slots, no reset
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   `TLBT_ASSERT_ALWAYS(a_count_bound, clock, reset || count_ff <= 2'd2)
   `TLBT_ASSERT(a_push_grows, clock, reset, push && !pop |=> count_ff == $past(count_ff) + 2'd1)
   `TLBT_ASSERT(a_pop_shrinks, clock, reset, pop && !push |=> count_ff == $past(count_ff) - 2'd1)

endmodule

// File: design/two_led_blink_timer_top.sv
// Top level of the two channel LED blink timer.
//
//   channel  ports        direction  carries
//   req      req_*        in         tick or control item
//   rsp      rsp_*        out        pins and flash flags after the item
//   csr      csr_*        in         register index and write data
//
// The channel add, compare and select run between the channel state and a two
// entry result queue, so items go back to back while the queue has room.
// A result is registered into the result queue when its item is accepted.
// req_ready drops only when both queue entries hold results not yet taken.
// Synchronous reset clears channel state and the queue; csr_ready is always high.
`timescale 1ns / 1ps

module two_led_blink_timer_top #(
   parameter int CHANNEL_COUNT = tlbt_pkg::CHANNEL_COUNT
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_ready,
   input  logic                                    req_action,
   input  logic [tlbt_pkg::STEP_WIDTH-1:0]         req_step,
   input  logic                                    req_channel,
   input  logic                                    req_flash_request,
   input  logic                                    req_off_request,
   input  logic                                    req_manual_level,
   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output logic                                    rsp_green_pin,
   output logic                                    rsp_red_pin,
   output logic                                    rsp_green_flash_pending,
   output logic                                    rsp_red_flash_pending,
   input  logic                                    csr_valid,
   output logic                                    csr_ready,
   input  logic [tlbt_pkg::CSR_INDEX_WIDTH-1:0]    csr_index,
   input  logic [tlbt_pkg::CSR_DATA_WIDTH-1:0]     csr_data
);

   localparam int NCH = tlbt_pkg::MAX_CHANNELS;

   tlbt_pkg::tlbt_chan_cfg_type cfg_ff [NCH];
   tlbt_pkg::tlbt_chan_out_type status [NCH];
   tlbt_pkg::tlbt_rsp_type      push_data;
   tlbt_pkg::tlbt_rsp_type      out_data;
   logic                        accept;
   logic                        has_room;
   logic                        csr_write;

   assign req_ready = has_room;
   assign accept    = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NCH; i++) begin
            cfg_ff[i].mode     <= tlbt_pkg::MODE_FLASH;
            cfg_ff[i].on_span  <= tlbt_pkg::SPAN_RESET;
            cfg_ff[i].off_span <= tlbt_pkg::SPAN_RESET;
            cfg_ff[i].invert   <= 1'b0;
         end
      end else if (csr_write) begin
         unique case (csr_index)
            tlbt_pkg::REG_GREEN_MODE:     cfg_ff[0].mode     <= csr_data[1:0];
            tlbt_pkg::REG_GREEN_ON_SPAN:  cfg_ff[0].on_span  <= csr_data;
            tlbt_pkg::REG_GREEN_OFF_SPAN: cfg_ff[0].off_span <= csr_data;
            tlbt_pkg::REG_GREEN_INVERT:   cfg_ff[0].invert   <= csr_data[0];
            tlbt_pkg::REG_RED_MODE:       cfg_ff[1].mode     <= csr_data[1:0];
            tlbt_pkg::REG_RED_ON_SPAN:    cfg_ff[1].on_span  <= csr_data;
            tlbt_pkg::REG_RED_OFF_SPAN:   cfg_ff[1].off_span <= csr_data;
            tlbt_pkg::REG_RED_INVERT:     cfg_ff[1].invert   <= csr_data[0];
            default: begin
            end
         endcase
      end
   end

   // Channels; those beyond the count stay at zero
   for (genvar g = 0; g < NCH; g++) begin : g_chan
      if (g < CHANNEL_COUNT) begin : g_used
         localparam logic CH_ID = 1'(g);
         tlbt_channel u_channel (
            .clock         (clock),
            .reset         (reset),
            .tick          (accept && req_action == tlbt_pkg::ACT_TICK),
            .ctl           (accept && req_action == tlbt_pkg::ACT_CONTROL
                            && req_channel == CH_ID),
            .step          (req_step),
            .flash_request (req_flash_request),
            .off_request   (req_off_request),
            .manual_level  (req_manual_level),
            .cfg           (cfg_ff[g]),
            .status        (status[g])
         );
      end else begin : g_unused
         assign status[g] = '0;
      end
   end

   // Result item
   always_comb begin
      push_data.green_pin           = status[0].pin;
      push_data.red_pin             = status[1].pin;
      push_data.green_flash_pending = status[0].armed;
      push_data.red_flash_pending   = status[1].armed;
   end

   tlbt_skid u_skid (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .push_data (push_data),
      .has_room  (has_room),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (out_data)
   );

   assign rsp_green_pin           = out_data.green_pin;
   assign rsp_red_pin             = out_data.red_pin;
   assign rsp_green_flash_pending = out_data.green_flash_pending;
   assign rsp_red_flash_pending   = out_data.red_flash_pending;

endmodule

// File: bench/tb.sv
// Self-checking testbench for the two channel LED blink timer.
`timescale 1ns / 1ps

import tlbt_pkg::*;

// Tracks channel state and config, and holds the pin and flash status due per accepted item.
class blink_scoreboard;
   tlbt_chan_cfg_type      cfg [2];
   logic [TIMER_WIDTH-1:0] timer [2];
   logic                   lit [2];
   logic                   armed [2];
   logic                   held_off [2];
   logic                   pin [2];
   tlbt_rsp_type           due_status [$];
   string                  field_tag [4];
   int unsigned            errors;

   function new();
      for (int ch = 0; ch < 2; ch++) begin
         cfg[ch].mode     = MODE_FLASH;
         cfg[ch].on_span  = SPAN_RESET;
         cfg[ch].off_span = SPAN_RESET;
         cfg[ch].invert   = 1'b0;
         timer[ch]    = '0;
         lit[ch]      = 1'b0;
         armed[ch]    = 1'b0;
         held_off[ch] = 1'b0;
         pin[ch]      = 1'b0;
      end
      // bit order of the packed result, lsb first
      field_tag = '{"red_flash_pending", "green_flash_pending", "red_pin", "green_pin"};
      errors = 0;
   endfunction

   function int outstanding();
      return due_status.size();
   endfunction

   function void set_reg(logic [CSR_INDEX_WIDTH-1:0] index, logic [CSR_DATA_WIDTH-1:0] data);
      case (index)
         REG_GREEN_MODE:     cfg[0].mode     = data[1:0];
         REG_GREEN_ON_SPAN:  cfg[0].on_span  = data;
         REG_GREEN_OFF_SPAN: cfg[0].off_span = data;
         REG_GREEN_INVERT:   cfg[0].invert   = data[0];
         REG_RED_MODE:       cfg[1].mode     = data[1:0];
         REG_RED_ON_SPAN:    cfg[1].on_span  = data;
         REG_RED_OFF_SPAN:   cfg[1].off_span = data;
         REG_RED_INVERT:     cfg[1].invert   = data[0];
         default: ;
      endcase
   endfunction

   // One tick of one channel: timer, level and pin.
   function void advance_channel(int ch, logic [STEP_WIDTH-1:0] step);
      logic [TIMER_WIDTH-1:0] period;
      logic [TIMER_WIDTH-1:0] t;
      period = TIMER_WIDTH'(cfg[ch].on_span) + TIMER_WIDTH'(cfg[ch].off_span);
      t = timer[ch] + TIMER_WIDTH'(step);
      if (held_off[ch]) begin
         lit[ch]   = 1'b0;
         timer[ch] = '0;
      end else if (cfg[ch].mode == MODE_FLASH) begin
         if (armed[ch]) begin
            lit[ch] = (t < TIMER_WIDTH'(cfg[ch].on_span));
            // flash done once past the full period
            if (t > period) begin
               t = '0;
               armed[ch] = 1'b0;
            end
            timer[ch] = t;
         end else begin
            lit[ch]   = 1'b0;
            timer[ch] = '0;
         end
      end else if (cfg[ch].mode == MODE_BLINK) begin
         lit[ch] = (t < TIMER_WIDTH'(cfg[ch].on_span));
         if (t >= period) t = '0;
         timer[ch] = t;
      end
      // manual and the unused mode hold level and timer
      pin[ch] = lit[ch] ^ cfg[ch].invert;
   endfunction

   function void note_item(logic action, logic [STEP_WIDTH-1:0] step, logic channel,
                           logic flash, logic off, logic level);
      tlbt_rsp_type st;
      if (action == ACT_TICK) begin
         for (int ch = 0; ch < CHANNEL_COUNT; ch++) advance_channel(ch, step);
      end else if (int'(channel) < CHANNEL_COUNT) begin
         if (flash) armed[channel] = 1'b1;
         held_off[channel] = off;
         lit[channel]      = level;
      end
      st.green_pin           = (CHANNEL_COUNT > 0) ? pin[0] : 1'b0;
      st.red_pin             = (CHANNEL_COUNT > 1) ? pin[1] : 1'b0;
      st.green_flash_pending = (CHANNEL_COUNT > 0) ? armed[0] : 1'b0;
      st.red_flash_pending   = (CHANNEL_COUNT > 1) ? armed[1] : 1'b0;
      due_status.push_back(st);
   endfunction

   function void check_result(tlbt_rsp_type got);
      tlbt_rsp_type want;
      if (due_status.size() == 0) begin
         errors++;
         $display("%0t: result %b with none expected", $time, got);
         return;
      end
      want = due_status.pop_front();
      for (int i = 0; i < 4; i++) begin
         if (want[i] !== got[i]) begin
            errors++;
            $display("%0t: %s expected %0b, got %0b", $time, field_tag[i], want[i], got[i]);
         end
      end
   endfunction
endclass

module tb;

   localparam int   CYCLE_LIMIT = 200000;
   localparam logic GREEN = 1'b0;
   localparam logic RED   = 1'b1;
   localparam logic [1:0] MODE_UNUSED = 2'd3;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_ready;
   logic                       req_action = ACT_TICK;
   logic [STEP_WIDTH-1:0]      req_step = '0;
   logic                       req_channel = GREEN;
   logic                       req_flash_request = 1'b0;
   logic                       req_off_request = 1'b0;
   logic                       req_manual_level = 1'b0;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   logic                       rsp_green_pin;
   logic                       rsp_red_pin;
   logic                       rsp_green_flash_pending;
   logic                       rsp_red_flash_pending;
   logic                       csr_valid = 1'b0;
   logic                       csr_ready;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [CSR_DATA_WIDTH-1:0]  csr_data = '0;

   logic        steady = 1'b0;
   int unsigned cycle_count = 0;

   blink_scoreboard sb = new();

   two_led_blink_timer_top uut (
      .clock                   (clock),
      .reset                   (reset),
      .req_valid               (req_valid),
      .req_ready               (req_ready),
      .req_action              (req_action),
      .req_step                (req_step),
      .req_channel             (req_channel),
      .req_flash_request       (req_flash_request),
      .req_off_request         (req_off_request),
      .req_manual_level        (req_manual_level),
      .rsp_valid               (rsp_valid),
      .rsp_ready               (rsp_ready),
      .rsp_green_pin           (rsp_green_pin),
      .rsp_red_pin             (rsp_red_pin),
      .rsp_green_flash_pending (rsp_green_flash_pending),
      .rsp_red_flash_pending   (rsp_red_flash_pending),
      .csr_valid               (csr_valid),
      .csr_ready               (csr_ready),
      .csr_index               (csr_index),
      .csr_data                (csr_data)
   );

   always #10 clock = ~clock;

   // Result side stalls at random outside the steady stretch.
   always @(negedge clock) begin
      rsp_ready <= !reset && (steady || $urandom_range(0, 99) >= 16);
   end

   // Handshake monitor: check results, note items and register writes.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready)
            sb.check_result({rsp_green_pin, rsp_red_pin,
                             rsp_green_flash_pending, rsp_red_flash_pending});
         if (req_valid && req_ready)
            sb.note_item(req_action, req_step, req_channel, req_flash_request,
                         req_off_request, req_manual_level);
         if (csr_valid && csr_ready)
            sb.set_reg(csr_index, csr_data);
      end
   end

   // Watchdog.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   task automatic send_item(logic action, logic [STEP_WIDTH-1:0] step, logic channel,
                            logic flash, logic off, logic level);
      while (!steady && $urandom_range(0, 99) < 16) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid         <= 1'b1;
      req_action        <= action;
      req_step          <= step;
      req_channel       <= channel;
      req_flash_request <= flash;
      req_off_request   <= off;
      req_manual_level  <= level;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic tick(logic [STEP_WIDTH-1:0] step);
      send_item(ACT_TICK, step, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
   endtask

   task automatic control(logic channel, logic flash, logic off, logic level);
      send_item(ACT_CONTROL, 8'($urandom_range(0, 255)), channel, flash, off, level);
   endtask

   // Lower valid and wait until every result is back.
   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (sb.outstanding() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_INDEX_WIDTH-1:0] index,
                            logic [CSR_DATA_WIDTH-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [1:0] pick_mode();
      case ($urandom_range(0, 3))
         0: return MODE_FLASH;
         1: return MODE_BLINK;
         2: return MODE_MANUAL;
         default: return MODE_UNUSED;
      endcase
   endfunction

   // Mostly short spans so flashes end and blinks wrap within a phase.
   function automatic logic [SPAN_WIDTH-1:0] pick_span();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 50) return 16'($urandom_range(0, 30));
      if (r < 75) return 16'($urandom_range(0, 300));
      if (r < 90) return 16'($urandom_range(0, 65535));
      return ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
   endfunction

   function automatic logic [STEP_WIDTH-1:0] pick_step();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 40) return 8'($urandom_range(0, 7));
      if (r < 80) return 8'($urandom_range(0, 255));
      if (r < 90) return 8'hFF;
      return 8'h00;
   endfunction

   task automatic random_item();
      if ($urandom_range(0, 99) < 30)
         control(1'($urandom_range(0, 1)), $urandom_range(0, 99) < 25,
                 $urandom_range(0, 99) < 12, 1'($urandom_range(0, 1)));
      else
         tick(pick_step());
   endtask

   // Stimulus.
   initial begin
      logic [SPAN_WIDTH-1:0] g_on, g_off, r_on, r_off;
      logic                  g_inv, r_inv;

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Flash mode at reset spans: unarmed tick, flash run through its boundaries.
      tick(8'd0);
      control(GREEN, 1'b1, 1'b0, 1'b0);
      tick(8'd5);
      tick(8'd5);
      tick(8'd10);
      tick(8'd1);
      // Force-off keeps the armed flag; a zero flash request leaves it armed.
      control(RED, 1'b1, 1'b1, 1'b1);
      tick(8'd255);
      control(RED, 1'b0, 1'b0, 1'b1);
      tick(8'd255);
      control(GREEN, 1'b1, 1'b0, 1'b1);
      tick(8'd255);
      control(RED, 1'b1, 1'b0, 1'b0);
      drain();

      // Blink with zero spans, manual level, both pins inverted.
      write_reg(REG_GREEN_MODE, 16'(MODE_BLINK));
      write_reg(REG_GREEN_ON_SPAN, 16'h0000);
      write_reg(REG_GREEN_OFF_SPAN, 16'h0000);
      write_reg(REG_GREEN_INVERT, 16'd1);
      write_reg(REG_RED_MODE, 16'(MODE_MANUAL));
      write_reg(REG_RED_INVERT, 16'd1);
      tick(8'd3);
      control(RED, 1'b0, 1'b0, 1'b1);
      tick(8'd0);
      control(GREEN, 1'b0, 1'b0, 1'b1);
      tick(8'd255);
      drain();

      // Unused mode holds; blink at the widest spans.
      write_reg(REG_GREEN_MODE, 16'(MODE_UNUSED));
      write_reg(REG_RED_MODE, 16'(MODE_BLINK));
      write_reg(REG_RED_ON_SPAN, 16'hFFFF);
      write_reg(REG_RED_OFF_SPAN, 16'hFFFF);
      write_reg(REG_RED_INVERT, 16'd0);
      control(GREEN, 1'b0, 1'b0, 1'b1);
      tick(8'd255);
      tick(8'd255);
      control(RED, 1'b0, 1'b1, 1'b0);
      tick(8'd255);
      control(RED, 1'b1, 1'b0, 1'b1);
      drain();

      // Random phases, each with a fresh register set.
      for (int p = 0; p < 10; p++) begin
         g_on = pick_span(); g_off = pick_span();
         r_on = pick_span(); r_off = pick_span();
         g_inv = 1'($urandom_range(0, 1));
         r_inv = 1'($urandom_range(0, 1));
         if (p == 0) begin
            g_on = '0; g_off = '0; r_on = '0; r_off = '0;
         end else if (p == 1) begin
            g_on = '1; g_off = '1; r_on = '1; r_off = '1;
         end
         write_reg(REG_GREEN_MODE, 16'((p == 2) ? MODE_FLASH : pick_mode()));
         write_reg(REG_GREEN_ON_SPAN, g_on);
         write_reg(REG_GREEN_OFF_SPAN, g_off);
         write_reg(REG_GREEN_INVERT, 16'(g_inv));
         write_reg(REG_RED_MODE, 16'((p == 2) ? MODE_BLINK : pick_mode()));
         write_reg(REG_RED_ON_SPAN, r_on);
         write_reg(REG_RED_OFF_SPAN, r_off);
         write_reg(REG_RED_INVERT, 16'(r_inv));
         steady = (p == 4);
         for (int n = 0; n < 195; n++) random_item();
         drain();
         steady = 1'b0;
      end

      repeat (10) @(posedge clock);
      if (sb.errors == 0 && sb.outstanding() == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
